@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the polygon vertex generator.
// Every form is sampled on clk and is switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition that must hold in the same cycle whenever the trigger is seen.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/rpvg_pkg.sv @@
// ----------------------------------------------------------------------------
// rpvg_pkg
// Types, widths and constants shared by the polygon vertex generator modules.
// ----------------------------------------------------------------------------
package rpvg_pkg;

  // Polygon limits and field widths.
  localparam int MAX_SIDES = 64;
  localparam int SIDES_MIN = 3;
  localparam int SIDE_W    = 7;
  localparam int COORD_W   = 16;
  localparam int GEOM_W    = 17;

  // Phase and CORDIC formats.
  localparam int PHASE_W = 32;
  localparam int TRIG_F  = 16;
  localparam int TRIG_W  = TRIG_F + 4;
  localparam int ANGLE_W = 33;
  localparam int ITER_W  = $clog2(TRIG_F);

  // Queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // The first vertex sits at three quarters of a turn.
  localparam logic [PHASE_W-1:0] PHASE_START = 32'hC000_0000;

  // CORDIC start vector: the inverse gain in Q1.16, rounded.
  localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 20'sd39797;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TABLE [TRIG_F] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
  };

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [GEOM_W-1:0]  geom_t;
  typedef logic [SIDE_W-1:0]         sides_t;
  typedef logic [PHASE_W-1:0]        phase_t;

  // One polygon job as handed from the front to the back.
  typedef struct packed {
    geom_t  center_x;
    geom_t  center_y;
    geom_t  radius_x;
    geom_t  radius_y;
    phase_t step;
    sides_t sides;
  } job_t;

endpackage

@@ rtl/rpvg_front.sv @@
// ----------------------------------------------------------------------------
// rpvg_front
// Accepts rectangles, derives center and radii, and computes the phase step
// for the configured side count with a bit-serial restoring divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpvg_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            rect_valid,
  output logic            rect_stall,
  input  rpvg_pkg::coord_t rect_left,
  input  rpvg_pkg::coord_t rect_top,
  input  rpvg_pkg::coord_t rect_right,
  input  rpvg_pkg::coord_t rect_bottom,
  input  logic            cfg_wen,
  input  rpvg_pkg::sides_t cfg_wdata,
  output logic            push,
  output rpvg_pkg::job_t  push_job,
  input  logic            full
);
  import rpvg_pkg::*;

  localparam int DIV_STEPS = PHASE_W + 1;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t       state;
  sides_t             side_count;
  sides_t             sides;
  geom_t              center_x;
  geom_t              center_y;
  geom_t              radius_x;
  geom_t              radius_y;
  logic [PHASE_W:0]   quo;
  logic [SIDE_W-1:0]  rem;
  logic [DCNT_W-1:0]  bit_cnt;
  logic [SIDE_W:0]    rem_sh;
  logic [SIDE_W:0]    rem_diff;
  logic               ge;
  logic               accept;
  geom_t              sum_x;
  geom_t              sum_y;
  geom_t              diff_x;
  geom_t              diff_y;

  // Halve a signed value, truncating toward zero.
  function automatic geom_t half_toward_zero(input geom_t s);
    geom_t t;
    t = s + $signed({{(GEOM_W-1){1'b0}}, s[GEOM_W-1]});
    return t >>> 1;
  endfunction

  // Side count register; writes outside the legal range are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      side_count <= SIDE_W'(SIDES_MIN);
    end else if (cfg_wen && cfg_wdata >= SIDE_W'(SIDES_MIN) &&
                 cfg_wdata <= SIDE_W'(MAX_SIDES)) begin
      side_count <= cfg_wdata;
    end
  end

  // Rectangle sums and differences on 17 bits.
  assign sum_x  = GEOM_W'(rect_left) + GEOM_W'(rect_right);
  assign sum_y  = GEOM_W'(rect_top) + GEOM_W'(rect_bottom);
  assign diff_x = GEOM_W'(rect_right) - GEOM_W'(rect_left);
  assign diff_y = GEOM_W'(rect_bottom) - GEOM_W'(rect_top);

  assign rect_stall = (state != F_IDLE);
  assign accept     = rect_valid && (state == F_IDLE);
  assign push       = (state == F_PUSH) && !full;

  // One quotient bit per cycle: shift in the next dividend bit and compare.
  assign rem_sh   = {rem, quo[PHASE_W]};
  assign rem_diff = rem_sh - {1'b0, sides};
  assign ge       = (rem_sh >= {1'b0, sides});

  // Control state machine.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            state <= F_DIV;
          end
        end
        F_DIV: begin
          if (bit_cnt == DCNT_W'(DIV_STEPS - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // Geometry and divider datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      center_x <= half_toward_zero(sum_x);
      center_y <= half_toward_zero(sum_y);
      radius_x <= half_toward_zero(diff_x);
      radius_y <= half_toward_zero(diff_y);
      sides    <= side_count;
      // Dividend is one full turn plus half the side count, for rounding.
      quo      <= ((PHASE_W+1)'(1) << PHASE_W) | (PHASE_W+1)'(side_count >> 1);
      rem      <= '0;
      bit_cnt  <= '0;
    end else if (state == F_DIV) begin
      quo     <= {quo[PHASE_W-1:0], ge};
      rem     <= ge ? rem_diff[SIDE_W-1:0] : rem_sh[SIDE_W-1:0];
      bit_cnt <= bit_cnt + DCNT_W'(1);
    end
  end

  // Job handed to the queue.
  always_comb begin
    push_job.center_x = center_x;
    push_job.center_y = center_y;
    push_job.radius_x = radius_x;
    push_job.radius_y = radius_y;
    push_job.step     = quo[PHASE_W-1:0];
    push_job.sides    = sides;
  end

  `ASSERT_ALWAYS(a_side_count_legal,
    side_count >= SIDE_W'(SIDES_MIN) && side_count <= SIDE_W'(MAX_SIDES),
    "side count register left its legal range")

endmodule

@@ rtl/rpvg_queue.sv @@
// ----------------------------------------------------------------------------
// rpvg_queue
// Short job queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpvg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rpvg_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output rpvg_pkg::job_t pop_job,
  output logic           empty
);
  import rpvg_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign pop_job = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= (QPTR_W+1)'(QDEPTH),
    "job queue fill count exceeds its depth")
  `ASSERT_IMPLIES(a_no_push_full, push, !full, "job pushed into a full queue")
  `ASSERT_IMPLIES(a_no_pop_empty, pop, !empty, "job popped from an empty queue")

endmodule

@@ rtl/rpvg_back.sv @@
// ----------------------------------------------------------------------------
// rpvg_back
// Walks the phase accumulator over one polygon, runs an iterative CORDIC for
// each vertex, scales and places the result, and drives the vertex channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpvg_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  output logic             pop,
  input  rpvg_pkg::job_t   pop_job,
  output logic             vertex_valid,
  input  logic             vertex_stall,
  output rpvg_pkg::coord_t vertex_x,
  output rpvg_pkg::coord_t vertex_y,
  output rpvg_pkg::sides_t vertex_index,
  output logic             last_vertex
);
  import rpvg_pkg::*;

  localparam int PROD_W = GEOM_W + TRIG_W;
  localparam int SUM_W  = PROD_W + 3;
  localparam int Q_W    = SUM_W - TRIG_F;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (TRIG_F - 1);
  localparam logic [SUM_W-1:0] TRUNC_BIAS = (SUM_W'(1) << TRIG_F) - SUM_W'(1);
  localparam logic signed [Q_W-1:0] Q_MAX =
    {{(Q_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN =
    {{(Q_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  typedef enum logic [6:0] {
    B_IDLE   = 7'b0000001,
    B_START  = 7'b0000010,
    B_ROTATE = 7'b0000100,
    B_MAP    = 7'b0001000,
    B_MUL    = 7'b0010000,
    B_SUM    = 7'b0100000,
    B_PLACE  = 7'b1000000
  } back_state_t;

  back_state_t               state;
  job_t                      cur;
  phase_t                    phase;
  sides_t                    vcount;
  logic signed [TRIG_W-1:0]  cx;
  logic signed [TRIG_W-1:0]  cy;
  logic signed [ANGLE_W-1:0] cz;
  logic [ITER_W-1:0]         iter;
  logic [1:0]                quad;
  logic signed [TRIG_W-1:0]  cos_r;
  logic signed [TRIG_W-1:0]  sin_r;
  logic signed [PROD_W-1:0]  prod_x;
  logic signed [PROD_W-1:0]  prod_y;
  logic signed [SUM_W-1:0]   sum_x;
  logic signed [SUM_W-1:0]   sum_y;
  logic signed [TRIG_W-1:0]  dx;
  logic signed [TRIG_W-1:0]  dy;
  logic signed [ANGLE_W-1:0] atan_step;
  logic                      out_free;
  logic                      is_last;

  // Divide by 2^TRIG_F truncating toward zero, then clamp to 16 bits.
  function automatic coord_t place_round(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0]        biased;
    logic signed [Q_W-1:0]   q;
    biased = v + (v[SUM_W-1] ? TRUNC_BIAS : '0);
    q      = biased[SUM_W-1:TRIG_F];
    if (q > Q_MAX) begin
      q = Q_MAX;
    end else if (q < Q_MIN) begin
      q = Q_MIN;
    end
    return q[COORD_W-1:0];
  endfunction

  assign pop      = (state == B_IDLE) && !empty;
  assign out_free = !vertex_valid || !vertex_stall;
  assign is_last  = ((vcount + SIDE_W'(1)) == cur.sides);

  // One CORDIC micro-rotation; shifts floor toward minus infinity.
  assign dx        = cy >>> iter;
  assign dy        = cx >>> iter;
  assign atan_step = $signed({1'b0, ATAN_TABLE[iter]});

  // Sequencer over the vertices of one polygon.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (!empty) begin
            state <= B_START;
          end
        end
        B_START:  state <= B_ROTATE;
        B_ROTATE: begin
          if (iter == ITER_W'(TRIG_F - 1)) begin
            state <= B_MAP;
          end
        end
        B_MAP:    state <= B_MUL;
        B_MUL:    state <= B_SUM;
        B_SUM:    state <= B_PLACE;
        B_PLACE: begin
          if (out_free) begin
            state <= is_last ? B_IDLE : B_START;
          end
        end
        default:  state <= B_IDLE;
      endcase
    end
  end

  // Job, phase and vertex count.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PHASE_START;
      vcount <= '0;
    end else if (pop) begin
      phase  <= PHASE_START;
      vcount <= '0;
    end else if (state == B_PLACE && out_free) begin
      phase  <= phase + cur.step;
      vcount <= vcount + SIDE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_job;
    end
  end

  // CORDIC iterations on the low 30 bits of the angle.
  always_ff @(posedge clk) begin
    if (state == B_START) begin
      cx   <= CORDIC_X0;
      cy   <= '0;
      cz   <= $signed({3'b000, phase[PHASE_W-3:0]});
      quad <= phase[PHASE_W-1:PHASE_W-2];
      iter <= '0;
    end else if (state == B_ROTATE) begin
      if (!cz[ANGLE_W-1]) begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - atan_step;
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + atan_step;
      end
      iter <= iter + ITER_W'(1);
    end
  end

  // Quadrant fold, scaling and placement.
  always_ff @(posedge clk) begin
    if (state == B_MAP) begin
      unique case (quad)
        2'd0: begin
          cos_r <= cx;
          sin_r <= cy;
        end
        2'd1: begin
          cos_r <= -cy;
          sin_r <= cx;
        end
        2'd2: begin
          cos_r <= -cx;
          sin_r <= -cy;
        end
        default: begin
          cos_r <= cy;
          sin_r <= -cx;
        end
      endcase
    end
    if (state == B_MUL) begin
      prod_x <= cur.radius_x * cos_r;
      prod_y <= cur.radius_y * sin_r;
    end
    if (state == B_SUM) begin
      sum_x <= SUM_W'(prod_x) + (SUM_W'(cur.center_x) <<< TRIG_F) + ROUND_HALF;
      sum_y <= SUM_W'(prod_y) + (SUM_W'(cur.center_y) <<< TRIG_F) + ROUND_HALF;
    end
  end

  // Output register; a finished vertex waits here while the next one runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_valid <= 1'b0;
    end else if (state == B_PLACE && out_free) begin
      vertex_valid <= 1'b1;
    end else if (!vertex_stall) begin
      vertex_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_PLACE && out_free) begin
      vertex_x     <= place_round(sum_x);
      vertex_y     <= place_round(sum_y);
      vertex_index <= vcount;
      last_vertex  <= is_last;
    end
  end

  `ASSERT_IMPLIES(a_index_bound, vertex_valid, vertex_index < SIDE_W'(MAX_SIDES),
    "vertex index beyond the largest polygon")

endmodule

@@ rtl/regular_polygon_vertex_generator_unit.sv @@
// ----------------------------------------------------------------------------
// Regular polygon vertex generator
// Each rectangle transaction yields side_count vertex transactions, the top
// vertex first, the last one marked by last_vertex. Each vertex goes through
// the vertex engine in turn: a start step, 16 CORDIC iterations of the
// shared rotation unit, quadrant fold, multiply, sum and placement.
// The front computes the phase step with a bit-serial divider and parks
// the job in a two-entry queue, so that work overlaps the previous polygon.
// side_count is written through cfg_wen and cfg_wdata; values outside 3..64
// are dropped. Write it only while the block is idle.
// ----------------------------------------------------------------------------
module regular_polygon_vertex_generator_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             rect_valid,
  output logic             rect_stall,
  input  rpvg_pkg::coord_t rect_left,
  input  rpvg_pkg::coord_t rect_top,
  input  rpvg_pkg::coord_t rect_right,
  input  rpvg_pkg::coord_t rect_bottom,
  output logic             vertex_valid,
  input  logic             vertex_stall,
  output rpvg_pkg::coord_t vertex_x,
  output rpvg_pkg::coord_t vertex_y,
  output rpvg_pkg::sides_t vertex_index,
  output logic             last_vertex,
  input  logic             cfg_wen,
  input  rpvg_pkg::sides_t cfg_wdata
);
  import rpvg_pkg::*;

  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t push_job;
  job_t pop_job;

  // Front: rectangle intake, geometry and step division.
  rpvg_front u_front (
    .clk         (clk),
    .rst         (rst),
    .rect_valid  (rect_valid),
    .rect_stall  (rect_stall),
    .rect_left   (rect_left),
    .rect_top    (rect_top),
    .rect_right  (rect_right),
    .rect_bottom (rect_bottom),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .push        (push),
    .push_job    (push_job),
    .full        (full)
  );

  // Job queue between the two halves.
  rpvg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  // Back: vertex engine and output register.
  rpvg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .pop          (pop),
    .pop_job      (pop_job),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .vertex_index (vertex_index),
    .last_vertex  (last_vertex)
  );

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Polygon vertex generator testbench
// Drives rectangle transactions into the vertex generator and checks every
// vertex transaction against a predictor that models the phase stepping,
// the CORDIC rotation and the rounding and saturation of the coordinates.
// Directed tests cover the field extremes, reversed edges and the side_count
// register limits. Random traffic follows, with random idling on both sides
// and one long output hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpvg_pkg::*;

  // Run limits and idle lengths.
  localparam int unsigned CYCLE_LIMIT   = 8_000_000;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          END_CYCLES    = 100;
  localparam int          HOLD_CYCLES   = 800;
  localparam int          PRINT_CAP     = 40;

  // Register limits as seen by the predictor.
  localparam int SIDES_HIGHEST = 100;

  // Phase and CORDIC constants of the predictor.
  localparam phase_t TOP_PHASE       = 32'hC000_0000;
  localparam longint CORDIC_GAIN_Q24 = 10188014;
  localparam int     ROT_STEPS       = 16;
  localparam int     FRAC            = 16;
  localparam logic [31:0] ATAN_TURNS [ROT_STEPS] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
  };

  typedef struct packed {
    coord_t x;
    coord_t y;
    sides_t idx;
    logic   last;
  } vertex_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   rect_valid = 1'b0;
  logic   rect_stall;
  coord_t rect_left = '0;
  coord_t rect_top = '0;
  coord_t rect_right = '0;
  coord_t rect_bottom = '0;
  logic   vertex_valid;
  logic   vertex_stall = 1'b0;
  coord_t vertex_x;
  coord_t vertex_y;
  sides_t vertex_index;
  logic   last_vertex;
  logic   cfg_wen = 1'b0;
  sides_t cfg_wdata = '0;

  // Predictor state and checking bookkeeping.
  vertex_t     pending_vertices[$];
  int          sides_now = SIDES_MIN;
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned open_left = 0;
  int unsigned stall_left = 0;

  regular_polygon_vertex_generator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .rect_valid   (rect_valid),
    .rect_stall   (rect_stall),
    .rect_left    (rect_left),
    .rect_top     (rect_top),
    .rect_right   (rect_right),
    .rect_bottom  (rect_bottom),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .vertex_index (vertex_index),
    .last_vertex  (last_vertex),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Idle length: mostly none or short, a few long.
  function automatic int unsigned pick_idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Rotation-mode CORDIC over one phase; returns cosine and sine in Q1.16.
  function automatic void cordic_cos_sin(input phase_t ang, output longint c,
                                         output longint s);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = (CORDIC_GAIN_Q24 + 128) >>> 8;
    y = 0;
    z = longint'(ang[29:0]);
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TURNS[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TURNS[i]);
      end
    end
    // The top two phase bits pick the quadrant that the result folds into.
    case (ang[31:30])
      2'b00: begin c = x; s = y; end
      2'b01: begin c = -y; s = x; end
      2'b10: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  // Scales, offsets and rounds one coordinate, then saturates it.
  function automatic coord_t place_coord(input int radius, input longint trig,
                                         input int center);
    longint v;
    longint q;
    v = longint'(radius) * trig + longint'(center) * (longint'(1) << FRAC)
        + (longint'(1) << (FRAC - 1));
    q = (v >= 0) ? (v >>> FRAC) : -((-v) >>> FRAC);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return coord_t'(q);
  endfunction

  // Queues every vertex that one accepted rectangle must produce.
  function automatic void predict_polygon(input coord_t l, input coord_t t,
                                          input coord_t r, input coord_t b);
    int              rad_x;
    int              rad_y;
    int              cen_x;
    int              cen_y;
    longint unsigned step;
    phase_t          phase;
    longint          c;
    longint          s;
    vertex_t         v;
    rad_x = (int'(r) - int'(l)) / 2;
    rad_y = (int'(b) - int'(t)) / 2;
    cen_x = (int'(l) + int'(r)) / 2;
    cen_y = (int'(t) + int'(b)) / 2;
    step  = ((64'd1 << 32) + longint'(sides_now / 2)) / longint'(sides_now);
    phase = TOP_PHASE;
    for (int k = 0; k < sides_now; k++) begin
      cordic_cos_sin(phase, c, s);
      v.x    = place_coord(rad_x, c, cen_x);
      v.y    = place_coord(rad_y, s, cen_y);
      v.idx  = sides_t'(k);
      v.last = (k + 1 == sides_now);
      pending_vertices.push_back(v);
      phase = phase + step[31:0];
    end
  endfunction

  // One line per mismatch; the count keeps going past the print cap.
  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t ns: mismatch on %s: got %0d, expected %0d",
               $time, what, got, want);
    mismatch_count++;
  endtask

  // Output side: random stall pattern, or a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_req) begin
      vertex_stall <= 1'b1;
      hold_left    <= HOLD_CYCLES - 1;
    end else if (hold_left != 0) begin
      vertex_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (open_left != 0) begin
      vertex_stall <= 1'b0;
      open_left    <= open_left - 1;
    end else if (stall_left != 0) begin
      vertex_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else begin
      vertex_stall <= 1'b0;
      open_left    <= ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 30);
      stall_left   <= pick_idle_len();
    end
  end

  // Each vertex transaction is compared with the oldest expectation.
  always @(posedge clk) begin : check_vertices
    vertex_t want;
    if (!rst && vertex_valid && !vertex_stall) begin
      if (pending_vertices.size() == 0) begin
        report_mismatch("vertex with no expectation, index", int'(vertex_index), -1);
      end else begin
        want = pending_vertices.pop_front();
        if (vertex_x !== want.x)
          report_mismatch("vertex_x", int'(vertex_x), int'(want.x));
        if (vertex_y !== want.y)
          report_mismatch("vertex_y", int'(vertex_y), int'(want.y));
        if (vertex_index !== want.idx)
          report_mismatch("vertex_index", int'(vertex_index), int'(want.idx));
        if (last_vertex !== want.last)
          report_mismatch("last_vertex", int'(last_vertex), int'(want.last));
      end
    end
  end

  // Sends one rectangle transaction after an optional idle gap.
  task automatic send_rect(input coord_t l, input coord_t t, input coord_t r,
                           input coord_t b, input int unsigned gap);
    if (gap != 0) begin
      rect_valid  <= 1'b0;
      rect_left   <= coord_t'($urandom);
      rect_top    <= coord_t'($urandom);
      rect_right  <= coord_t'($urandom);
      rect_bottom <= coord_t'($urandom);
      repeat (gap) @(posedge clk);
    end
    rect_valid  <= 1'b1;
    rect_left   <= l;
    rect_top    <= t;
    rect_right  <= r;
    rect_bottom <= b;
    @(posedge clk);
    while (rect_stall) @(posedge clk);
    predict_polygon(l, t, r, b);
  endtask

  // Stops sending and waits until every expected vertex has come out.
  task automatic wait_idle();
    rect_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes side_count; the block must be idle.
  task automatic write_sides(input sides_t value);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    cfg_wdata <= sides_t'($urandom);
    if (value >= SIDES_MIN && value <= SIDES_HIGHEST && value <= MAX_SIDES)
      sides_now = value;
  endtask

  // Random rectangle: noise, well-formed, reversed, extreme-edged and tiny boxes.
  task automatic make_rect(output coord_t l, output coord_t t, output coord_t r,
                           output coord_t b);
    int unsigned kind;
    int          cx;
    int          cy;
    int          w;
    int          h;
    kind = $urandom_range(0, 99);
    cx = int'($urandom_range(0, 65535)) - 32768;
    cy = int'($urandom_range(0, 65535)) - 32768;
    w  = $urandom_range(0, 3000);
    h  = $urandom_range(0, 3000);
    if (kind < 40) begin
      l = coord_t'($urandom); t = coord_t'($urandom);
      r = coord_t'($urandom); b = coord_t'($urandom);
    end else if (kind < 75) begin
      l = coord_t'(cx - w / 2); r = coord_t'(cx + (w + 1) / 2);
      t = coord_t'(cy - h / 2); b = coord_t'(cy + (h + 1) / 2);
    end else if (kind < 85) begin
      r = coord_t'(cx - w / 2); l = coord_t'(cx + (w + 1) / 2);
      b = coord_t'(cy - h / 2); t = coord_t'(cy + (h + 1) / 2);
    end else if (kind < 95) begin
      l = ($urandom_range(0, 1) != 0) ? 16'sh8000 : coord_t'($urandom);
      t = ($urandom_range(0, 1) != 0) ? 16'sh8000 : coord_t'($urandom);
      r = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : coord_t'($urandom);
      b = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : coord_t'($urandom);
    end else begin
      l = coord_t'(cx); r = coord_t'(cx + $urandom_range(0, 1));
      t = coord_t'(cy); b = coord_t'(cy + $urandom_range(0, 1));
    end
  endtask

  // The register holds three sides out of reset.
  task automatic test_default_sides();
    send_rect(-16'sd100, -16'sd50, 16'sd100, 16'sd50, 0);
    wait_idle();
  endtask

  // Field extremes, reversed edges, empty boxes and odd sizes that truncate.
  task automatic test_field_extremes();
    send_rect(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 0);
    send_rect(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, pick_idle_len());
    send_rect(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, pick_idle_len());
    send_rect(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, pick_idle_len());
    send_rect(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 0);
    send_rect(16'sd5, 16'sd5, 16'sd5, 16'sd5, pick_idle_len());
    send_rect(-16'sd7, -16'sd3, 16'sd4, 16'sd8, 0);
    send_rect(16'sd0, 16'sd0, -16'sd1, -16'sd1, pick_idle_len());
    wait_idle();
  endtask

  // side_count at both limits, with out-of-range writes that must be dropped.
  task automatic test_sides_register();
    write_sides(7'd64);
    send_rect(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 0);
    send_rect(-16'sd1000, -16'sd300, 16'sd1000, 16'sd300, pick_idle_len());
    wait_idle();
    write_sides(7'd65);
    write_sides(7'd100);
    write_sides(7'd127);
    write_sides(7'd0);
    write_sides(7'd2);
    send_rect(-16'sd20, -16'sd20, 16'sd21, 16'sd21, 0);
    wait_idle();
    write_sides(7'd3);
    send_rect(16'sd100, 16'sd200, 16'sd300, 16'sd400, 0);
    wait_idle();
    write_sides(7'd17);
    send_rect(-16'sd500, 16'sd700, 16'sd900, -16'sd100, 0);
    wait_idle();
  endtask

  // Long output hold-off while rectangles keep coming, then a full drain.
  task automatic test_backpressure();
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
    write_sides(7'd6);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int k = 0; k < 6; k++) begin
      make_rect(l, t, r, b);
      send_rect(l, t, r, b, 0);
    end
    wait_idle();
  endtask

  // Phases of random rectangles, each after a random side_count write.
  task automatic test_random_traffic();
    coord_t      l;
    coord_t      t;
    coord_t      r;
    coord_t      b;
    int unsigned pick;
    sides_t      sides;
    bit          no_gaps;
    for (int phase_num = 0; phase_num < 11; phase_num++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      sides = sides_t'($urandom_range(3, 8));
      else if (pick < 85) sides = sides_t'($urandom_range(9, 24));
      else if (pick < 93) sides = sides_t'($urandom_range(25, 64));
      else if (pick < 97) sides = sides_t'($urandom_range(65, 127));
      else                sides = sides_t'($urandom_range(0, 2));
      write_sides(sides);
      no_gaps = (phase_num % 3 == 1);
      for (int k = 0; k < 30; k++) begin
        make_rect(l, t, r, b);
        send_rect(l, t, r, b, no_gaps ? 0 : pick_idle_len());
      end
      wait_idle();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    test_default_sides();
    test_field_extremes();
    test_sides_register();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rpvg_pkg.sv
rtl/rpvg_front.sv
rtl/rpvg_queue.sv
rtl/rpvg_back.sv
rtl/regular_polygon_vertex_generator_unit.sv
dv/tb.sv
